### design/tovc_pkg.sv
// Shared types and constants for the toaster oven controller.
// No dependencies; every other design file imports this package.
package tovc_pkg;

    localparam int KNOB_W     = 8;
    localparam int TIME_W     = 9;
    localparam int TEMP_W     = 10;
    localparam int TPS_W      = 4;
    localparam int PRESS_W    = 8;
    localparam int TICK_W     = 16;
    localparam int LED_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;

    // Cook time times ticks per second, and the reciprocal-scaled factor
    localparam int PROD_W  = TIME_W + TPS_W;
    localparam int RECIP_W = PROD_W + 1;
    localparam int LED_K_W = TPS_W + RECIP_W;

    localparam logic [PRESS_W-1:0] HOLD_LIMIT_RST = 8'd5;
    localparam logic [TPS_W-1:0]   TPS_RST        = 4'd5;
    localparam logic [TEMP_W-1:0]  BAKE_TEMP_RST  = 10'd350;
    localparam logic [TEMP_W-1:0]  BROIL_TEMP_RST = 10'd500;
    localparam logic [TEMP_W-1:0]  TEMP_BASE_RST  = 10'd300;
    localparam logic [TEMP_W-1:0]  TEMP_MAX       = 10'd1023;
    localparam logic [LED_W-1:0]   LED_ALL_ON     = 8'hFF;
    localparam logic [LED_W-1:0]   LED_SAT        = 8'd255;

    typedef enum logic [2:0] {
        PH_SETUP  = 3'd0,
        PH_SELECT = 3'd1,
        PH_COOK   = 3'd2,
        PH_RESET  = 3'd3,
        PH_ALERT  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        MODE_BAKE  = 2'd0,
        MODE_TOAST = 2'd1,
        MODE_BROIL = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_LIMIT = 3'd0,
        CFG_TICKS_SEC  = 3'd1,
        CFG_BAKE_TEMP  = 3'd2,
        CFG_BROIL_TEMP = 3'd3,
        CFG_TEMP_BASE  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // The bake default only matters at the moment it is written; the core
    // takes it straight from the write port.
    typedef struct packed {
        logic [PRESS_W-1:0] hold_limit;
        logic [TPS_W-1:0]   tps;
        logic [TEMP_W-1:0]  broil_temp;
        logic [TEMP_W-1:0]  temp_base;
    } cfg_t;

    typedef struct packed {
        logic              tick;
        logic              knob_valid;
        logic [KNOB_W-1:0] knob_value;
        logic              select_press;
        logic              select_release;
        logic              start_press;
        logic              start_release;
    } item_t;

    typedef struct packed {
        phase_t             oven_phase;
        mode_t              cook_mode;
        logic [TIME_W-1:0]  set_time;
        logic [TIME_W-1:0]  time_left;
        logic [TEMP_W-1:0]  temperature;
        logic               editing_temp;
        logic [LED_W-1:0]   led_bar;
        logic               display_inverted;
        logic               display_refresh;
    } res_t;

endpackage

### design/tovc_cfg.sv
// Configuration register file of the toaster oven controller.
// Depends on tovc_pkg; also holds the LED interval scale factor.
module tovc_cfg #(
    parameter int LED_DIVISOR = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tovc_pkg::cfg_wr_t             cfg_wr,
    output tovc_pkg::cfg_t                cfg,
    output logic [tovc_pkg::LED_K_W-1:0]  led_k
);
    import tovc_pkg::*;

    // floor(p / LED_DIVISOR) == (p * LED_RECIP) >> LED_SHIFT for p < 2**PROD_W
    localparam int LED_SHIFT = PROD_W + $clog2(LED_DIVISOR);
    localparam logic [RECIP_W-1:0] LED_RECIP =
        RECIP_W'((2**LED_SHIFT + LED_DIVISOR - 1) / LED_DIVISOR);

    cfg_t                 cfg_reg;
    logic [LED_K_W-1:0]   led_k_reg;
    logic [LED_K_W-1:0]   led_k_next;

    // Pre-scale ticks per second by the reciprocal at write time
    assign led_k_next = LED_K_W'(cfg_wr.data[TPS_W-1:0]) * LED_K_W'(LED_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_limit <= HOLD_LIMIT_RST;
            cfg_reg.tps        <= TPS_RST;
            cfg_reg.broil_temp <= BROIL_TEMP_RST;
            cfg_reg.temp_base  <= TEMP_BASE_RST;
            led_k_reg          <= LED_K_W'(TPS_RST) * LED_K_W'(LED_RECIP);
        end
        else if (cfg_wr.we)
        begin
            case (cfg_wr.idx)
                CFG_HOLD_LIMIT: cfg_reg.hold_limit <= cfg_wr.data[PRESS_W-1:0];
                CFG_TICKS_SEC:
                begin
                    cfg_reg.tps <= cfg_wr.data[TPS_W-1:0];
                    led_k_reg   <= led_k_next;
                end
                CFG_BROIL_TEMP: cfg_reg.broil_temp <= cfg_wr.data[TEMP_W-1:0];
                CFG_TEMP_BASE:  cfg_reg.temp_base  <= cfg_wr.data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg   = cfg_reg;
    assign led_k = led_k_reg;

endmodule

### design/tovc_core.sv
// Oven state machine: state registers and the one-pass event update.
// Depends on tovc_pkg; fed by the input stage and tovc_cfg.
module tovc_core #(
    parameter int LED_DIVISOR = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  tovc_pkg::item_t               item,
    input  tovc_pkg::cfg_t                cfg,
    input  logic [tovc_pkg::LED_K_W-1:0]  led_k,
    input  tovc_pkg::cfg_wr_t             cfg_wr,
    output tovc_pkg::res_t                res
);
    import tovc_pkg::*;

    localparam int LED_SHIFT = PROD_W + $clog2(LED_DIVISOR);
    localparam int MUL_W     = TIME_W + LED_K_W;

    phase_t              phase_reg, phase_next;
    mode_t               mode_reg, mode_next;
    logic [TIME_W-1:0]   time_set_reg, time_set_next;
    logic [TIME_W-1:0]   time_left_reg, time_left_next;
    logic [TEMP_W-1:0]   temp_reg, temp_next;
    logic [TEMP_W-1:0]   saved_temp_reg, saved_temp_next;
    logic [TICK_W-1:0]   tick_count_reg, tick_count_next;
    logic [TICK_W-1:0]   press_stamp_reg, press_stamp_next;
    logic [TPS_W-1:0]    second_phase_reg, second_phase_next;
    logic [LED_W-1:0]    led_interval_reg, led_interval_next;
    logic [LED_W-1:0]    led_ticks_reg, led_ticks_next;
    logic [LED_W-1:0]    led_pattern_reg, led_pattern_next;
    logic                edit_temp_reg, edit_temp_next;
    logic                flash_reg, flash_next;
    logic                redraw;

    // One countdown tick, computed from the held state
    logic [LED_W-1:0]    ck_lticks, ck_pattern;
    logic [TPS_W-1:0]    ck_sphase;
    logic [TIME_W-1:0]   ck_tleft;
    logic                ck_redraw, ck_alert;

    logic [TICK_W-1:0]   held;
    logic [TEMP_W:0]     knob_temp;
    logic                knob_sets_temp;
    logic [TIME_W-1:0]   ts_eff;
    logic [MUL_W-1:0]    led_prod;
    logic [MUL_W-1:0]    led_quot;
    logic [LED_W-1:0]    led_int_sat;
    logic                bake_wr;

    always_comb
    begin
        ck_lticks  = led_ticks_reg + 8'd1;
        ck_pattern = led_pattern_reg;
        if (ck_lticks == led_interval_reg && time_left_reg != '0)
        begin
            ck_pattern = led_pattern_reg >> 1;
            ck_lticks  = '0;
        end
        ck_sphase = second_phase_reg + 4'd1;
        ck_tleft  = time_left_reg;
        ck_redraw = 1'b0;
        ck_alert  = 1'b0;
        if (ck_sphase >= cfg.tps)
        begin
            ck_sphase = '0;
            if (time_left_reg != '0)
                ck_tleft = time_left_reg - 9'd1;
            ck_redraw = 1'b1;
        end
        if (ck_tleft == '0)
        begin
            ck_tleft  = time_set_reg;
            ck_alert  = 1'b1;
            ck_redraw = 1'b1;
        end
    end

    // Knob value and the LED interval for a start in the same event
    assign knob_sets_temp = (mode_reg == MODE_BAKE) && edit_temp_reg;
    assign knob_temp      = (TEMP_W+1)'(item.knob_value) + (TEMP_W+1)'(cfg.temp_base);
    assign ts_eff = (item.knob_valid && !knob_sets_temp) ?
                    TIME_W'(item.knob_value) + 9'd1 : time_set_reg;
    assign led_prod    = MUL_W'(ts_eff) * MUL_W'(led_k);
    assign led_quot    = led_prod >> LED_SHIFT;
    assign led_int_sat = (led_quot > MUL_W'(LED_SAT)) ? LED_SAT : led_quot[LED_W-1:0];

    assign tick_count_next = item.tick ? tick_count_reg + 16'd1 : tick_count_reg;
    assign held            = tick_count_next - press_stamp_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        mode_next         = mode_reg;
        time_set_next     = time_set_reg;
        time_left_next    = time_left_reg;
        temp_next         = temp_reg;
        saved_temp_next   = saved_temp_reg;
        press_stamp_next  = press_stamp_reg;
        second_phase_next = second_phase_reg;
        led_interval_next = led_interval_reg;
        led_ticks_next    = led_ticks_reg;
        led_pattern_next  = led_pattern_reg;
        edit_temp_next    = edit_temp_reg;
        flash_next        = flash_reg;
        redraw            = 1'b0;

        case (phase_reg)
            PH_SETUP:
            begin
                if (item.knob_valid)
                begin
                    if (knob_sets_temp)
                        temp_next = knob_temp[TEMP_W] ? TEMP_MAX : knob_temp[TEMP_W-1:0];
                    else
                    begin
                        time_set_next  = ts_eff;
                        time_left_next = ts_eff;
                    end
                    redraw = 1'b1;
                end
                if (item.select_press)
                begin
                    press_stamp_next = tick_count_next;
                    phase_next       = PH_SELECT;
                end
                if (item.start_press)
                begin
                    phase_next        = PH_COOK;
                    redraw            = 1'b1;
                    led_pattern_next  = LED_ALL_ON;
                    led_ticks_next    = '0;
                    second_phase_next = '0;
                    led_interval_next = led_int_sat;
                end
            end
            PH_SELECT:
            begin
                if (item.select_release)
                begin
                    if (held < TICK_W'(cfg.hold_limit))
                    begin
                        case (mode_reg)
                            MODE_BAKE:
                                mode_next = MODE_TOAST;
                            MODE_TOAST:
                            begin
                                mode_next       = MODE_BROIL;
                                saved_temp_next = temp_reg;
                                temp_next       = cfg.broil_temp;
                            end
                            default:
                            begin
                                mode_next = MODE_BAKE;
                                temp_next = saved_temp_reg;
                            end
                        endcase
                    end
                    else if (mode_reg == MODE_BAKE)
                        edit_temp_next = !edit_temp_reg;
                    redraw     = 1'b1;
                    phase_next = PH_SETUP;
                end
            end
            PH_COOK:
            begin
                if (item.tick)
                begin
                    led_ticks_next    = ck_lticks;
                    led_pattern_next  = ck_pattern;
                    second_phase_next = ck_sphase;
                    time_left_next    = ck_tleft;
                    redraw            = ck_redraw;
                    if (ck_alert)
                        phase_next = PH_ALERT;
                end
                // A stop press overrides an alert raised by the same tick
                if (item.start_press)
                begin
                    press_stamp_next = tick_count_next;
                    phase_next       = PH_RESET;
                end
            end
            PH_RESET:
            begin
                if (item.start_release)
                    phase_next = PH_COOK;
                if (item.tick)
                begin
                    if (held >= TICK_W'(cfg.hold_limit))
                    begin
                        phase_next     = PH_SETUP;
                        time_left_next = time_set_reg;
                        redraw         = 1'b1;
                    end
                    else
                    begin
                        led_ticks_next    = ck_lticks;
                        led_pattern_next  = ck_pattern;
                        second_phase_next = ck_sphase;
                        time_left_next    = ck_tleft;
                        redraw            = ck_redraw;
                        if (ck_alert)
                            phase_next = PH_ALERT;
                    end
                end
            end
            PH_ALERT:
            begin
                if (item.tick)
                begin
                    flash_next = !flash_reg;
                    redraw     = 1'b1;
                end
                if (item.start_release)
                begin
                    flash_next = 1'b1;
                    phase_next = PH_SETUP;
                    redraw     = 1'b1;
                end
            end
            default:
                phase_next = PH_SETUP;
        endcase
    end

    assign bake_wr = cfg_wr.we && (cfg_wr.idx == CFG_BAKE_TEMP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SETUP;
            mode_reg         <= MODE_BAKE;
            time_set_reg     <= 9'd1;
            time_left_reg    <= 9'd1;
            temp_reg         <= BAKE_TEMP_RST;
            saved_temp_reg   <= '0;
            tick_count_reg   <= '0;
            press_stamp_reg  <= '0;
            second_phase_reg <= '0;
            led_interval_reg <= '0;
            led_ticks_reg    <= '0;
            led_pattern_reg  <= LED_ALL_ON;
            edit_temp_reg    <= 1'b0;
            flash_reg        <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg        <= phase_next;
                mode_reg         <= mode_next;
                time_set_reg     <= time_set_next;
                time_left_reg    <= time_left_next;
                temp_reg         <= temp_next;
                saved_temp_reg   <= saved_temp_next;
                tick_count_reg   <= tick_count_next;
                press_stamp_reg  <= press_stamp_next;
                second_phase_reg <= second_phase_next;
                led_interval_reg <= led_interval_next;
                led_ticks_reg    <= led_ticks_next;
                led_pattern_reg  <= led_pattern_next;
                edit_temp_reg    <= edit_temp_next;
                flash_reg        <= flash_next;
            end
            // A new bake default lands in the live or the parked temperature
            if (bake_wr)
            begin
                if (mode_reg == MODE_BROIL)
                    saved_temp_reg <= cfg_wr.data[TEMP_W-1:0];
                else
                    temp_reg <= cfg_wr.data[TEMP_W-1:0];
            end
        end
    end

    always_comb
    begin
        res.oven_phase       = phase_next;
        res.cook_mode        = mode_next;
        res.set_time         = time_set_next;
        res.time_left        = time_left_next;
        res.temperature      = temp_next;
        res.editing_temp     = edit_temp_next;
        res.led_bar          = (phase_next == PH_COOK || phase_next == PH_RESET) ?
                               led_pattern_next : '0;
        res.display_inverted = (phase_next == PH_ALERT) && !flash_next;
        res.display_refresh  = redraw;
    end

endmodule

### design/toaster_oven_controller.sv
// Top level of the toaster oven controller: stream ports, input and result stages.
// Depends on tovc_pkg, tovc_cfg and tovc_core.
//
// Usage:
//   Each transfer on the s_axis side is one event: a timer tick, a knob
//   reading and press/release edges of the selector and start/stop buttons.
//   Every event yields exactly one result transfer on the m_axis side with
//   the oven phase, mode, times, temperature, LED bar and display flags as
//   they stand after that event.
//   Configuration is written through cfg_we/cfg_index/cfg_data while no
//   event is in flight; a write takes effect at the clock edge.
// Pipeline and throughput:
//   An accepted event is held in the input register, the state update
//   runs in one combinational pass from there, and the result is registered.
//   One event per cycle is sustained while m_axis_tready is high; the state
//   register loop is the only feedback path.
// Reset:
//   rst_n clears both stages, the configuration to its defaults and the oven
//   to setup/bake with a one-second cook time.
// Stalls:
//   When m_axis_tready is low the result register holds, the input register
//   keeps its event, and s_axis_tready drops only once both are occupied.
module toaster_oven_controller #(
    parameter int LED_DIVISOR = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Event channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] tick, [1] knob_valid, [9:2] knob_value, [10] select_press,
    // [11] select_release, [12] start_press, [13] start_release, [15:14] zero
    input  logic [tovc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] oven_phase, [4:3] cook_mode, [13:5] set_time, [22:14] time_left,
    // [32:23] temperature, [33] editing_temp, [41:34] led_bar,
    // [42] display_inverted, [43] display_refresh, [47:44] zero
    output logic [tovc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [tovc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tovc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tovc_pkg::*;

    logic                in_valid_reg;
    item_t               in_item_reg;
    item_t               in_item;
    logic                out_valid_reg;
    res_t                out_res_reg;
    res_t                res;
    logic                advance;
    cfg_wr_t             cfg_wr;
    cfg_t                cfg;
    logic [LED_K_W-1:0]  led_k;

    // Unpack the event fields
    assign in_item.tick           = s_axis_tdata[0];
    assign in_item.knob_valid     = s_axis_tdata[1];
    assign in_item.knob_value     = s_axis_tdata[9:2];
    assign in_item.select_press   = s_axis_tdata[10];
    assign in_item.select_release = s_axis_tdata[11];
    assign in_item.start_press    = s_axis_tdata[12];
    assign in_item.start_release  = s_axis_tdata[13];

    assign cfg_wr.we   = cfg_we;
    assign cfg_wr.idx  = cfg_index;
    assign cfg_wr.data = cfg_data;

    // Move the held event into the result stage whenever that stage frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_item_reg <= in_item;
    end

    tovc_cfg #(
        .LED_DIVISOR (LED_DIVISOR)
    ) u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .cfg    (cfg),
        .led_k  (led_k)
    );

    tovc_core #(
        .LED_DIVISOR (LED_DIVISOR)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .led_k   (led_k),
        .cfg_wr  (cfg_wr),
        .res     (res)
    );

    // Result stage: load on advance, drop once the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000,
                            out_res_reg.display_refresh,
                            out_res_reg.display_inverted,
                            out_res_reg.led_bar,
                            out_res_reg.editing_temp,
                            out_res_reg.temperature,
                            out_res_reg.time_left,
                            out_res_reg.set_time,
                            out_res_reg.cook_mode,
                            out_res_reg.oven_phase};

endmodule

### design/tovc_chk.sv
// Port-level checks for the toaster oven controller, bound to the top level.
// Depends on tovc_pkg.
module tovc_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [tovc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import tovc_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // Event side backs up only when the result side is full and stalled
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("event side stalled without a stalled result");

    // Inverted display only in alert
    a_invert: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[42] |-> m_axis_tdata[2:0] == PH_ALERT)
        else $error("display inverted outside alert");

    // LED bar lit only while cooking or waiting on a stop
    a_leds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[41:34] != 8'd0
            |-> m_axis_tdata[2:0] == PH_COOK || m_axis_tdata[2:0] == PH_RESET)
        else $error("LED bar lit outside cooking");

    // Cook time never reads zero
    a_set_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[13:5] != 9'd0)
        else $error("set time reads zero");

endmodule

bind toaster_oven_controller tovc_chk u_tovc_chk (.*);

### tb/tovc_checker.sv
// Scoreboard for the toaster oven controller: watches the event, result and configuration
// ports, predicts every result transfer and compares it field by field.
// Depends on tovc_pkg.
module tovc_checker #(
    parameter int LED_DIV = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ev_valid,
    input  logic                              ev_ready,
    input  logic [tovc_pkg::IN_TDATA_W-1:0]   ev_data,
    input  logic                              res_valid,
    input  logic                              res_ready,
    input  logic [tovc_pkg::OUT_TDATA_W-1:0]  res_data,
    input  logic                              cfg_we,
    input  logic [tovc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tovc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                errors,
    output int                                outstanding
);
    import tovc_pkg::*;

    // Configuration copy
    logic [PRESS_W-1:0] long_ticks;
    logic [TPS_W-1:0]   tps;
    logic [TEMP_W-1:0]  bake_dflt;
    logic [TEMP_W-1:0]  broil_temp;
    logic [TEMP_W-1:0]  knob_base;

    // Oven state copy
    phase_t             oven_ph;
    mode_t              oven_mode;
    logic [TIME_W-1:0]  cook_secs;
    logic [TIME_W-1:0]  secs_left;
    logic [TEMP_W-1:0]  cur_temp;
    logic [TEMP_W-1:0]  stashed_temp;
    logic [TICK_W-1:0]  tick_ctr;
    logic [TICK_W-1:0]  press_at;
    logic [TPS_W-1:0]   sub_sec;
    logic [LED_W-1:0]   bar_step;
    logic [LED_W-1:0]   bar_ctr;
    logic [LED_W-1:0]   bar_leds;
    logic               temp_edit;
    logic               flash_on;

    res_t expected_results[$];

    function automatic void reset_oven();
        long_ticks   = HOLD_LIMIT_RST;
        tps          = TPS_RST;
        bake_dflt    = BAKE_TEMP_RST;
        broil_temp   = BROIL_TEMP_RST;
        knob_base    = TEMP_BASE_RST;
        oven_ph      = PH_SETUP;
        oven_mode    = MODE_BAKE;
        cook_secs    = 9'd1;
        secs_left    = 9'd1;
        cur_temp     = BAKE_TEMP_RST;
        stashed_temp = '0;
        tick_ctr     = '0;
        press_at     = '0;
        sub_sec      = '0;
        bar_step     = '0;
        bar_ctr      = '0;
        bar_leds     = LED_ALL_ON;
        temp_edit    = 1'b0;
        flash_on     = 1'b0;
    endfunction

    function automatic void write_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
        case (cfg_idx_t'(idx))
            CFG_HOLD_LIMIT: long_ticks = val[PRESS_W-1:0];
            CFG_TICKS_SEC:  tps = val[TPS_W-1:0];
            CFG_BAKE_TEMP:
            begin
                // a new bake default lands in the stash while broiling
                bake_dflt = val;
                if (oven_mode == MODE_BROIL)
                    stashed_temp = bake_dflt;
                else
                    cur_temp = bake_dflt;
            end
            CFG_BROIL_TEMP: broil_temp = val;
            CFG_TEMP_BASE:  knob_base = val;
            default: ;
        endcase
    endfunction

    // One countdown tick; returns 1 when the display redraws.
    function automatic logic countdown_tick();
        logic redraw;
        redraw  = 1'b0;
        bar_ctr = bar_ctr + 8'd1;
        if (bar_ctr == bar_step && secs_left != '0)
        begin
            bar_leds = bar_leds >> 1;
            bar_ctr  = '0;
        end
        sub_sec = sub_sec + 4'd1;
        if (sub_sec >= tps)
        begin
            sub_sec = '0;
            if (secs_left != '0)
                secs_left = secs_left - 9'd1;
            redraw = 1'b1;
        end
        if (secs_left == '0)
        begin
            secs_left = cook_secs;
            oven_ph   = PH_ALERT;
            redraw    = 1'b1;
        end
        return redraw;
    endfunction

    function automatic res_t oven_step(logic [IN_TDATA_W-1:0] d);
        logic              tick, knob_vld, sel_dn, sel_up, st_dn, st_up, redraw;
        logic [KNOB_W-1:0] knob;
        logic [TICK_W-1:0] held;
        int unsigned       sum;
        res_t              r;
        tick     = d[0];
        knob_vld = d[1];
        knob     = d[9:2];
        sel_dn   = d[10];
        sel_up   = d[11];
        st_dn    = d[12];
        st_up    = d[13];
        redraw   = 1'b0;
        if (tick)
            tick_ctr = tick_ctr + 16'd1;
        held = tick_ctr - press_at;
        case (oven_ph)
            PH_SETUP:
            begin
                if (knob_vld)
                begin
                    if (oven_mode == MODE_BAKE && temp_edit)
                    begin
                        sum = 32'(knob) + 32'(knob_base);
                        cur_temp = (sum > 32'(TEMP_MAX)) ? TEMP_MAX : sum[TEMP_W-1:0];
                    end
                    else
                    begin
                        cook_secs = 9'(knob) + 9'd1;
                        secs_left = cook_secs;
                    end
                    redraw = 1'b1;
                end
                if (sel_dn)
                begin
                    press_at = tick_ctr;
                    oven_ph  = PH_SELECT;
                end
                if (st_dn)
                begin
                    oven_ph  = PH_COOK;
                    redraw   = 1'b1;
                    bar_leds = LED_ALL_ON;
                    bar_ctr  = '0;
                    sub_sec  = '0;
                    sum      = (32'(cook_secs) * 32'(tps)) / 32'(LED_DIV);
                    bar_step = (sum > 255) ? LED_SAT : sum[LED_W-1:0];
                end
            end
            PH_SELECT:
            begin
                if (sel_up)
                begin
                    if (held < TICK_W'(long_ticks))
                    begin
                        case (oven_mode)
                            MODE_BAKE:  oven_mode = MODE_TOAST;
                            MODE_TOAST: oven_mode = MODE_BROIL;
                            default:    oven_mode = MODE_BAKE;
                        endcase
                        if (oven_mode == MODE_BROIL)
                        begin
                            stashed_temp = cur_temp;
                            cur_temp     = broil_temp;
                        end
                        else if (oven_mode == MODE_BAKE)
                            cur_temp = stashed_temp;
                    end
                    else if (oven_mode == MODE_BAKE)
                        temp_edit = ~temp_edit;
                    redraw  = 1'b1;
                    oven_ph = PH_SETUP;
                end
            end
            PH_COOK:
            begin
                if (tick && countdown_tick())
                    redraw = 1'b1;
                // a press on the very tick that ends cooking still wins
                if (st_dn)
                begin
                    press_at = tick_ctr;
                    oven_ph  = PH_RESET;
                end
            end
            PH_RESET:
            begin
                if (st_up)
                    oven_ph = PH_COOK;
                if (tick)
                begin
                    if (held >= TICK_W'(long_ticks))
                    begin
                        oven_ph   = PH_SETUP;
                        secs_left = cook_secs;
                        redraw    = 1'b1;
                    end
                    else if (countdown_tick())
                        redraw = 1'b1;
                end
            end
            PH_ALERT:
            begin
                if (tick)
                begin
                    flash_on = ~flash_on;
                    redraw   = 1'b1;
                end
                if (st_up)
                begin
                    flash_on = 1'b1;
                    oven_ph  = PH_SETUP;
                    redraw   = 1'b1;
                end
            end
            default: oven_ph = PH_SETUP;
        endcase
        r.oven_phase       = oven_ph;
        r.cook_mode        = oven_mode;
        r.set_time         = cook_secs;
        r.time_left        = secs_left;
        r.temperature      = cur_temp;
        r.editing_temp     = temp_edit;
        r.led_bar          = (oven_ph == PH_COOK || oven_ph == PH_RESET) ? bar_leds : '0;
        r.display_inverted = (oven_ph == PH_ALERT && !flash_on);
        r.display_refresh  = redraw;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            reset_oven();
            expected_results.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
                write_setting(cfg_index, cfg_data);
            // retire before predicting: a result never belongs to the event of its own edge
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transfer, expected none, got %h",
                             $time, res_data);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("oven_phase", int'(want.oven_phase), int'(res_data[2:0]));
                    check_field("cook_mode", int'(want.cook_mode), int'(res_data[4:3]));
                    check_field("set_time", int'(want.set_time), int'(res_data[13:5]));
                    check_field("time_left", int'(want.time_left), int'(res_data[22:14]));
                    check_field("temperature", int'(want.temperature),
                                int'(res_data[32:23]));
                    check_field("editing_temp", int'(want.editing_temp), int'(res_data[33]));
                    check_field("led_bar", int'(want.led_bar), int'(res_data[41:34]));
                    check_field("display_inverted", int'(want.display_inverted),
                                int'(res_data[42]));
                    check_field("display_refresh", int'(want.display_refresh),
                                int'(res_data[43]));
                end
            end
            if (ev_valid && ev_ready)
                expected_results.push_back(oven_step(ev_data));
        end
        outstanding = expected_results.size();
    end

endmodule

### tb/toaster_oven_controller_tb.sv
// Top of the toaster oven controller testbench: clock, reset, event stimulus,
// configuration phases and the final verdict.
// Depends on tovc_pkg, toaster_oven_controller and tovc_checker.
module toaster_oven_controller_tb;
    import tovc_pkg::*;

    localparam int LED_DIVISOR = 12;
    // Leave a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 285;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    int errors;
    int outstanding;
    int cycle_count = 0;
    int events_sent = 0;
    // percent of cycles in which the event side idles / the result side stalls
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // shadow of the press and timing settings, used to size button holds
    int long_now = int'(HOLD_LIMIT_RST);
    int tps_now = int'(TPS_RST);

    toaster_oven_controller #(
        .LED_DIVISOR(LED_DIVISOR)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    tovc_checker #(
        .LED_DIV(LED_DIVISOR)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev_valid    (s_axis_tvalid),
        .ev_ready    (s_axis_tready),
        .ev_data     (s_axis_tdata),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_data    (m_axis_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stall the result side at random; update only on the falling edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Drive one event and hold it until the transfer completes. Idle cycles are
    // inserted first at the current rate; tvalid stays high across back-to-back
    // events, so it is never dropped and raised within one step.
    task automatic send_event(input logic tick, input logic knob_vld,
                              input logic [KNOB_W-1:0] knob,
                              input logic sel_dn, input logic sel_up,
                              input logic st_dn, input logic st_up);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, st_up, st_dn, sel_up, sel_dn, knob, knob_vld, tick};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        events_sent++;
    endtask

    // Advance the timer; the knob byte wiggles but is not flagged as valid.
    task automatic send_ticks(input int n);
        repeat (n)
            send_event(1'b1, 1'b0, 8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    // Hold length for a button: mostly short, a quarter of the time just long.
    function automatic int hold_len();
        int short_max;
        short_max = (long_now > 4) ? 3 : ((long_now > 0) ? long_now - 1 : 0);
        if ($urandom_range(3) == 0)
            return long_now + $urandom_range(1);
        return $urandom_range(short_max);
    endfunction

    // Drop tvalid and wait until every expected result has come back.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Reprogram every register while the block is idle.
    task automatic configure(input int hold_limit, input int ticks_sec, input int bake,
                             input int broil, input int base);
        drain();
        write_reg(CFG_HOLD_LIMIT, hold_limit);
        write_reg(CFG_TICKS_SEC, ticks_sec);
        write_reg(CFG_BAKE_TEMP, bake);
        write_reg(CFG_BROIL_TEMP, broil);
        write_reg(CFG_TEMP_BASE, base);
        long_now = hold_limit;
        tps_now  = ticks_sec;
    endtask

    // One random burst: mostly full cook cycles, some selector play, some noise.
    task automatic random_burst();
        int pick;
        int knob;
        int full;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            // noise: every field random
            repeat ($urandom_range(1, 4))
                send_event(1'($urandom_range(1)), 1'($urandom_range(1)),
                           8'($urandom_range(255)),
                           1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        else if (pick < 35)
        begin
            // selector press and release, optionally followed by a knob turn
            send_event(1'($urandom_range(1)), 1'($urandom_range(1)),
                       8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, 1'b0);
            send_ticks(hold_len());
            send_event(1'($urandom_range(1)), 1'b0, 8'($urandom_range(255)),
                       1'b0, 1'b1, 1'b0, 1'b0);
            if ($urandom_range(1))
                send_event(1'b0, 1'b1, 8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 1'b0);
        end
        else
        begin
            // set a cook time (mostly short so the countdown reaches the alert)
            knob = ($urandom_range(99) < 15) ? $urandom_range(255) : $urandom_range(3);
            send_event(1'b0, 1'b1, 8'(knob), 1'b0, 1'b0, 1'b0, 1'b0);
            send_event(1'($urandom_range(1)), 1'b0, 8'($urandom_range(255)),
                       1'b0, 1'b0, 1'b1, 1'b0);
            send_event(1'b0, 1'b0, 8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 1'b1);
            full = (knob + 1) * ((tps_now > 0) ? tps_now : 1) + 2;
            if (full > 70)
                full = 70;
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                // pause the countdown with a start/stop press, then resume
                send_ticks($urandom_range(1, full / 2));
                send_event(1'($urandom_range(1)), 1'b0, 8'($urandom_range(255)),
                           1'b0, 1'b0, 1'b1, 1'b0);
                send_ticks(hold_len());
                send_event(1'($urandom_range(1)), 1'b0, 8'($urandom_range(255)),
                           1'b0, 1'b0, 1'b0, 1'b1);
                send_ticks(full);
            end
            else if (pick < 55)
            begin
                // cancel with a long start/stop press
                send_ticks($urandom_range(0, full / 2));
                send_event(1'($urandom_range(1)), 1'b0, 8'($urandom_range(255)),
                           1'b0, 1'b0, 1'b1, 1'b0);
                send_ticks(long_now + $urandom_range(1));
                send_event(1'($urandom_range(1)), 1'b0, 8'($urandom_range(255)),
                           1'b0, 1'b0, 1'b0, 1'b1);
            end
            else
                send_ticks(full);
            // flash in the alert a little, then acknowledge it
            send_ticks($urandom_range(4));
            send_event(1'($urandom_range(1)), 1'b0, 8'($urandom_range(255)),
                       1'b0, 1'b0, 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        int target;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed walk from the reset state with default settings.
        send_event(1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);    // shortest cook time
        send_event(1'b0, 1'b1, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0);  // longest cook time
        send_event(1'b0, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0);    // short press: toast
        send_event(1'b0, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
        send_event(1'b0, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0);    // release ignored in setup
        send_event(1'b0, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);    // broil: stash temperature
        send_event(1'b0, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_event(1'b0, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);    // back to bake: restore
        send_event(1'b0, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0);    // long press: edit temp
        send_ticks(5);
        send_event(1'b0, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
        send_event(1'b0, 1'b1, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0);  // knob sets temperature
        // every edge at once: knob, select and start all act, ending in cooking
        send_event(1'b1, 1'b1, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0);    // tick, then stop press
        send_event(1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1);    // resume cooking
        send_event(1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
        send_ticks(5);                                           // held long: cancel

        // Random phases: each pairs one setting of the registers with one idling mix.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1: configure(1, 1, 0, 1023, 768);
                2: configure(255, 10, 1023, 0, 0);
                // zero long press, LED interval and knob temperature saturation
                3: configure(0, 15, 200, 700, 1023);
                // zero ticks per second: every cooking tick ends a second
                4: configure(3, 0, 350, 500, 300);
                default: ;
            endcase
            case (ph)
                1:
                begin
                    send_idle_pct  = 70;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 70;
                end
                3:
                begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            target = 25 + ITEMS_PER_PHASE * (ph + 1);
            while (events_sent < target)
                random_burst();
        end

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
